/* sv/wfa_pkg.sv */
package wfa_pkg;

   localparam int AddrWMax = 10;
   localparam int SizeW = 31;
   localparam int IdxW = 6;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_LOAD    = 2'd1,
      OP_REQUEST = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NOFIT  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_BADIDX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_READ
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [SizeW-1:0] size;
      logic [IdxW-1:0]  block_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IdxW-1:0]  chosen_index;
      logic [SizeW-1:0] remaining_size;
      logic [SizeW-1:0] original_size;
   } rsp_type;

   typedef struct packed {
      logic             rem_we;
      logic             orig_we;
      logic [AddrWMax-1:0] wr_addr;
      logic [SizeW-1:0] wr_rem;
      logic [SizeW-1:0] wr_orig;
      logic [AddrWMax-1:0] rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic [SizeW-1:0] rem;
      logic [SizeW-1:0] orig;
   } entry_type;

endpackage

/* sv/wfa_mem.sv */
module wfa_mem #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic                 clock,
   input  wfa_pkg::mem_cmd_type cmd,
   output wfa_pkg::entry_type   rd_data
);
   import wfa_pkg::*;

   logic [SizeW-1:0] rem_mem [DEPTH];
   logic [SizeW-1:0] orig_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.rem_we) begin
         rem_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_rem;
      end
      if (cmd.orig_we) begin
         orig_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_orig;
      end
      rd_data_ff.rem <= rem_mem[cmd.rd_addr[AW-1:0]];
      rd_data_ff.orig <= orig_mem[cmd.rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/wfa_ctrl.sv */
module wfa_ctrl #(
   parameter int MAX_ENTRIES = 64,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  wfa_pkg::req_type     req_data,
   output logic                 rsp_strobe,
   output wfa_pkg::rsp_type     rsp_data,
   output wfa_pkg::mem_cmd_type cmd,
   input  wfa_pkg::entry_type   rd_data
);
   import wfa_pkg::*;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic dat_valid_ff, dat_valid_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] dat_idx_ff, dat_idx_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [SizeW-1:0] best_rem_ff, best_rem_in;
   logic [SizeW-1:0] best_orig_ff, best_orig_in;
   logic [SizeW-1:0] size_ff, size_in;
   rsp_type rsp_ff, rsp_in;

   logic rd_bad;
   logic scan_done;
   logic [SizeW-1:0] new_rem;

   assign busy = (state_ff != S_IDLE);
   assign rd_bad = (32'(req_data.block_index) >= 32'(count_ff))
                || (32'(req_data.block_index) >= MAX_ENTRIES);
   assign scan_done = dat_valid_ff && (iss_ff == count_ff);
   assign new_rem = best_rem_ff - size_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.op == OP_REQUEST && count_ff != '0) begin
                  state_in = S_SCAN;
               end else if (req_data.op == OP_READ && !rd_bad) begin
                  state_in = S_READ;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: state_in = S_IDLE;
         S_READ:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      iss_in = iss_ff;
      dat_valid_in = 1'b0;
      dat_idx_in = dat_idx_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_rem_in = best_rem_ff;
      best_orig_in = best_orig_ff;
      size_in = size_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in = req_data.size;
               case (req_data.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in = '{STATUS_OK, '0, '0, '0};
                  end
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (32'(count_ff) >= MAX_ENTRIES) begin
                        rsp_in = '{STATUS_FULL, '0, '0, '0};
                     end else begin
                        cmd.rem_we = 1'b1;
                        cmd.orig_we = 1'b1;
                        cmd.wr_addr = AddrWMax'(count_ff[AW-1:0]);
                        cmd.wr_rem = req_data.size;
                        cmd.wr_orig = req_data.size;
                        count_in = count_ff + CW'(1);
                        rsp_in = '{STATUS_OK, IdxW'(count_ff), req_data.size,
                                   req_data.size};
                     end
                  end
                  OP_REQUEST: begin
                     found_in = 1'b0;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{STATUS_NOFIT, '0, '0, '0};
                     end else begin
                        cmd.rd_addr = '0;
                        iss_in = CW'(1);
                        dat_valid_in = 1'b1;
                        dat_idx_in = '0;
                     end
                  end
                  OP_READ: begin
                     if (rd_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{STATUS_BADIDX, '0, '0, '0};
                     end else begin
                        cmd.rd_addr = AddrWMax'(req_data.block_index);
                        dat_idx_in = AW'(req_data.block_index);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (iss_ff < count_ff) begin
               cmd.rd_addr = AddrWMax'(iss_ff[AW-1:0]);
               iss_in = iss_ff + CW'(1);
               dat_valid_in = 1'b1;
               dat_idx_in = iss_ff[AW-1:0];
            end
            if (dat_valid_ff && rd_data.rem >= size_ff
                && (!found_ff || rd_data.rem > best_rem_ff)) begin
               found_in = 1'b1;
               best_idx_in = dat_idx_ff;
               best_rem_in = rd_data.rem;
               best_orig_in = rd_data.orig;
            end
         end
         S_UPDATE: begin
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               cmd.rem_we = 1'b1;
               cmd.wr_addr = AddrWMax'(best_idx_ff);
               cmd.wr_rem = new_rem;
               rsp_in = '{STATUS_OK, IdxW'(best_idx_ff), new_rem, best_orig_ff};
            end else begin
               rsp_in = '{STATUS_NOFIT, '0, '0, '0};
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{STATUS_OK, IdxW'(dat_idx_ff), rd_data.rem, rd_data.orig};
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         iss_ff <= '0;
         dat_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         iss_ff <= iss_in;
         dat_valid_ff <= dat_valid_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_idx_ff <= dat_idx_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_orig_ff <= best_orig_in;
      size_ff <= size_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* sv/worst_fit_block_allocator.sv */
// Clear, load, a full-table load, a no-fit request on an empty table and a bad read
// give their beat in the cycle after acceptance; a good read first waits in S_READ for the registered memory read.
// A request on a table of N blocks scans all N of them through the registered read port
// of the block memory, then updates in S_UPDATE; busy is high meanwhile.
// The receiver cannot stall; each result beat is shown for one cycle.
// Synchronous reset empties the table; block memory contents are not cleared.
module worst_fit_block_allocator #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wfa_pkg::req_type req_data,
   output logic             rsp_strobe,
   output wfa_pkg::rsp_type rsp_data
);
   import wfa_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   mem_cmd_type cmd;
   entry_type rd_data;

   wfa_mem #(
      .DEPTH(MAX_ENTRIES),
      .AW(AW)
   ) u_mem (
      .clock(clock),
      .cmd(cmd),
      .rd_data(rd_data)
   );

   wfa_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .AW(AW),
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .cmd(cmd),
      .rd_data(rd_data)
   );

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_CLEAR) |=> (rsp_strobe && !busy))
      else $error("clear gave no result beat");

   a_rem_le_orig: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_OK)
      |-> (rsp_data.remaining_size <= rsp_data.original_size))
      else $error("remaining size exceeds original size");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted item");

endmodule

/* verif/wfa_alloc_checker.sv */
module wfa_alloc_checker #(
   parameter int TableDepth = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  wfa_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  wfa_pkg::rsp_type rsp_data,
   output int               outstanding,
   output int               failures,
   output int               beats_checked,
   output int               allocs_granted,
   output int               nofit_seen,
   output int               full_seen,
   output int               badidx_seen
);
   import wfa_pkg::*;

   logic [SizeW-1:0] rem_tbl [TableDepth];
   logic [SizeW-1:0] orig_tbl [TableDepth];
   int               entries_loaded;
   rsp_type          awaited_rsp [$];

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (failures < 50) begin
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      end
      failures++;
   endtask

   // Applies one accepted beat to the shadow table and returns the result it must give.
   function automatic rsp_type worst_fit_outcome(input req_type beat);
      rsp_type          res;
      logic             found;
      int               best;
      logic [SizeW-1:0] best_left;
      logic [SizeW-1:0] left;
      res       = '0;
      found     = 1'b0;
      best      = 0;
      best_left = '0;
      case (beat.op)
         OP_CLEAR: begin
            entries_loaded = 0;
            res.status = STATUS_OK;
         end
         OP_LOAD: begin
            if (entries_loaded >= TableDepth) begin
               res.status = STATUS_FULL;
            end else begin
               rem_tbl[entries_loaded]  = beat.size;
               orig_tbl[entries_loaded] = beat.size;
               res.status         = STATUS_OK;
               res.chosen_index   = entries_loaded[IdxW-1:0];
               res.remaining_size = beat.size;
               res.original_size  = beat.size;
               entries_loaded++;
            end
         end
         OP_REQUEST: begin
            for (int j = 0; j < entries_loaded; j++) begin
               if (rem_tbl[j] >= beat.size) begin
                  left = rem_tbl[j] - beat.size;
                  if (!found || left > best_left) begin
                     found     = 1'b1;
                     best      = j;
                     best_left = left;
                  end
               end
            end
            if (!found) begin
               res.status = STATUS_NOFIT;
            end else begin
               rem_tbl[best]      = best_left;
               res.status         = STATUS_OK;
               res.chosen_index   = best[IdxW-1:0];
               res.remaining_size = best_left;
               res.original_size  = orig_tbl[best];
               allocs_granted++;
            end
         end
         default: begin
            if (int'(beat.block_index) >= entries_loaded) begin
               res.status = STATUS_BADIDX;
            end else begin
               res.status         = STATUS_OK;
               res.chosen_index   = beat.block_index;
               res.remaining_size = rem_tbl[beat.block_index];
               res.original_size  = orig_tbl[beat.block_index];
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         entries_loaded = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("result beat with nothing pending", 0, rsp_data.status);
            end else begin
               want = awaited_rsp.pop_front();
               beats_checked++;
               case (want.status)
                  STATUS_NOFIT: nofit_seen++;
                  STATUS_FULL: full_seen++;
                  STATUS_BADIDX: badidx_seen++;
                  default: ;
               endcase
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", want.status, rsp_data.status);
               end
               if (rsp_data.chosen_index !== want.chosen_index) begin
                  report_mismatch("chosen_index", want.chosen_index, rsp_data.chosen_index);
               end
               if (rsp_data.remaining_size !== want.remaining_size) begin
                  report_mismatch("remaining_size", want.remaining_size,
                                  rsp_data.remaining_size);
               end
               if (rsp_data.original_size !== want.original_size) begin
                  report_mismatch("original_size", want.original_size,
                                  rsp_data.original_size);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            awaited_rsp.push_back(worst_fit_outcome(req_data));
         end
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

/* verif/tb_worst_fit_block_allocator.sv */
module tb_worst_fit_block_allocator;
   import wfa_pkg::*;

   localparam int Entries = 64;
   localparam int ItemTarget = 1800;
   localparam int IdleLimit = 4000;
   localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int outstanding;
   int failures;
   int beats_checked;
   int allocs_granted;
   int nofit_seen;
   int full_seen;
   int badidx_seen;

   int items_sent = 0;
   int table_fill = 0;
   int burst_left = 8;
   int idle_cycles = 0;

   worst_fit_block_allocator #(
      .MAX_ENTRIES(Entries)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   wfa_alloc_checker #(
      .TableDepth(Entries)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .outstanding(outstanding),
      .failures(failures),
      .beats_checked(beats_checked),
      .allocs_granted(allocs_granted),
      .nofit_seen(nofit_seen),
      .full_seen(full_seen),
      .badidx_seen(badidx_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type make_beat(input op_type op, input logic [SizeW-1:0] size,
                                         input logic [IdxW-1:0] idx);
      req_type beat;
      beat.op          = op;
      beat.size        = size;
      beat.block_index = idx;
      return beat;
   endfunction

   function automatic logic [SizeW-1:0] block_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return SizeW'($urandom_range(0, 255));
      else if (pick < 55) return SizeW'($urandom_range(0, 65535));
      else if (pick < 85) return SizeW'($urandom);
      else if (pick < 95) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return SizeW'(1);
            2: return SizeMax - SizeW'(1);
            default: return SizeMax;
         endcase
      end
      return SizeW'(1) << $urandom_range(0, SizeW - 1);
   endfunction

   function automatic logic [SizeW-1:0] request_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return SizeW'($urandom_range(0, 63));
      else if (pick < 65) return SizeW'($urandom_range(0, 4095));
      else if (pick < 70) return '0;
      return block_size();
   endfunction

   task automatic issue_item(input req_type beat);
      int gap;
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      case (beat.op)
         OP_CLEAR: table_fill = 0;
         OP_LOAD: if (table_fill < Entries) table_fill++;
         default: ;
      endcase
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic noise_item();
      issue_item(make_beat(op_type'($urandom_range(0, 3)), SizeW'($urandom),
                           IdxW'($urandom)));
   endtask

   // A burst of the table's life: optional clear, some loads, then mixed requests and reads.
   task automatic run_episode();
      int n_load;
      int n_ops;
      int pick;
      if ($urandom_range(0, 4) != 0) issue_item(make_beat(OP_CLEAR, SizeW'($urandom),
                                                          IdxW'($urandom)));
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      repeat (n_load) begin
         if ($urandom_range(0, 29) == 0) noise_item();
         issue_item(make_beat(OP_LOAD, block_size(), IdxW'($urandom)));
      end
      n_ops = $urandom_range(4, 30);
      repeat (n_ops) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            issue_item(make_beat(OP_REQUEST, request_size(), IdxW'($urandom)));
         end else if (pick < 85 && table_fill > 0) begin
            issue_item(make_beat(OP_READ, SizeW'($urandom),
                                 IdxW'($urandom_range(0, table_fill - 1))));
         end else if (pick < 95) begin
            issue_item(make_beat(OP_READ, SizeW'($urandom), IdxW'($urandom)));
         end else begin
            noise_item();
         end
      end
   endtask

   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: requests cannot fit and reads are out of range.
      issue_item(make_beat(OP_REQUEST, '0, '0));
      issue_item(make_beat(OP_READ, '0, '0));
      issue_item(make_beat(OP_READ, SizeMax, '1));
      issue_item(make_beat(OP_LOAD, '0, '1));
      issue_item(make_beat(OP_LOAD, SizeMax, '0));
      issue_item(make_beat(OP_LOAD, SizeW'(5), '0));
      issue_item(make_beat(OP_LOAD, SizeW'(5), '0));
      // A zero request takes the largest block and leaves it as it was.
      issue_item(make_beat(OP_REQUEST, '0, '1));
      issue_item(make_beat(OP_REQUEST, SizeMax, '0));
      // Two blocks tie on leftover; the lower index must win.
      issue_item(make_beat(OP_REQUEST, SizeW'(5), '0));
      issue_item(make_beat(OP_REQUEST, SizeW'(1), '0));
      issue_item(make_beat(OP_REQUEST, SizeMax, '0));
      issue_item(make_beat(OP_READ, '0, IdxW'(0)));
      issue_item(make_beat(OP_READ, '0, IdxW'(1)));
      issue_item(make_beat(OP_READ, '0, IdxW'(2)));
      issue_item(make_beat(OP_READ, '0, IdxW'(3)));
      issue_item(make_beat(OP_READ, '0, IdxW'(4)));
      issue_item(make_beat(OP_READ, '0, '1));
      issue_item(make_beat(OP_CLEAR, SizeMax, '1));
      issue_item(make_beat(OP_READ, '0, IdxW'(0)));
      issue_item(make_beat(OP_REQUEST, '0, '0));
      drain_results();

      while (items_sent < ItemTarget) begin
         run_episode();
         if ($urandom_range(0, 4) == 0) drain_results();
      end

      drain_results();
      repeat (80) @(posedge clock);
      $display("Drove %0d beats and checked %0d result beats.", items_sent, beats_checked);
      $display("Saw %0d allocations, %0d no-fit requests, %0d loads into a full table,",
               allocs_granted, nofit_seen, full_seen);
      $display("and %0d bad reads.", badidx_seen);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
